// ===== design/interpolated_correction_table_top_defines.svh =====
// Assertion macros for the interpolated correction table
`ifndef INTERPOLATED_CORRECTION_TABLE_TOP_DEFINES_SVH
`define INTERPOLATED_CORRECTION_TABLE_TOP_DEFINES_SVH
`ifndef SYNTH
`define ICT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ICT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ICT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ICT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/ict_pkg.sv =====
// Shared types and codes for the interpolated correction table
`default_nettype none
package ict_pkg;
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SIGN      = 3'd1;
    localparam logic [2:0] ST_NOBRACKET = 3'd2;
    localparam logic [2:0] ST_RADIUS    = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic [1:0] REG_RADIUS      = 2'd0;
    localparam logic [1:0] REG_RADIUS_LOW  = 2'd1;
    localparam logic [1:0] REG_RADIUS_HIGH = 2'd2;

    // divider request / response
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [32:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } t_div_rsp;
endpackage
`default_nettype wire

// ===== design/ict_ram.sv =====
// Generic single-port RAM with registered read
`default_nettype none
module ict_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_addr,
    input  wire [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== design/ict_div.sv =====
// Restoring divider, 64-bit numerator by 33-bit denominator, 32-bit quotient
`default_nettype none
module ict_div (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  ict_pkg::t_div_req i_req,
    output ict_pkg::t_div_rsp o_rsp
);
    import ict_pkg::*;

    logic [63:0] r_num, n_num;
    logic [32:0] r_den;
    logic [33:0] r_rem, n_rem;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    logic [33:0] w_sh;

    // one quotient bit per cycle; quotient bits shift into r_num
    always_comb begin
        w_sh  = {r_rem[32:0], r_num[63]};
        n_num = {r_num[62:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= {1'b0, r_den}) begin
            n_rem    = w_sh - {1'b0, r_den};
            n_num[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_num[31:0];
endmodule
`default_nettype wire

// ===== design/interpolated_correction_table_top.sv =====
// Top level: correction table with binary-search lookup and interpolation
// Clear or unused command goes straight to output. Load: check, multiply, 64-step
// divide; a row that fails the radius or full check is dropped. Lookup: check reads,
// binary search, bracket reads, then the divide when the bracket keys differ.
// One word at a time: a new word is taken only once the previous result is in the
// output register. Synchronous active-low reset clears count, radius bounds; radius 0xFF00.
`default_nettype none
`include "interpolated_correction_table_top_defines.svh"
module interpolated_correction_table_top #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: command[1:0], eta_value[33:2], corr_at_low[65:34],
    // corr_at_high[97:66], zero pad to 104
    input  wire [103:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // tdata: correction[31:0], status[34:32], entry_total[43:35], pad to 48
    output logic [47:0] m_axis_tdata,
    input  wire         i_cfg_we,
    input  wire [1:0]   i_cfg_index,
    input  wire [15:0]  i_cfg_wdata
);
    import ict_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_LMUL  = 11'b00000000010,
        S_DIV   = 11'b00000000100,
        S_MID   = 11'b00000001000,
        S_FIRST = 11'b00000010000,
        S_LAST  = 11'b00000100000,
        S_SRCH  = 11'b00001000000,
        S_BLO   = 11'b00010000000,
        S_BHI   = 11'b00100000000,
        S_CLO   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state r_state;
    logic [15:0] r_radius, r_rlo, r_rhi;
    logic [CW-1:0] r_count;
    logic [1:0]  r_cmd;
    logic [31:0] r_eta, r_cl, r_ch;
    logic [AW-1:0] r_lo, r_hi;
    logic [31:0] r_le, r_c1;
    logic [1:0]  r_sub;
    logic [63:0] r_p0, r_p1;
    logic [32:0] r_den;
    logic [31:0] r_corr;
    logic [2:0]  r_status;
    logic        r_ovalid;
    logic [47:0] r_odata;
    logic        r_dstart;

    logic          w_we;
    logic [AW-1:0] w_addr;
    logic [31:0]   w_eta_q, w_corr_q, w_corr_wd;
    t_div_req      w_dreq;
    t_div_rsp      w_drsp;

    ict_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_eta_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(r_eta), .o_rdata(w_eta_q));
    ict_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_corr_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(w_corr_wd), .o_rdata(w_corr_q));

    assign w_dreq.start = r_dstart;
    assign w_dreq.num   = r_p0 + r_p1;
    assign w_dreq.den   = r_den;
    ict_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    assign w_corr_wd = w_drsp.quo;
    assign w_we = (r_state == S_DIV) && w_drsp.done && (r_cmd == CMD_LOAD);

    logic [AW-1:0] w_step, w_mid;
    logic signed [31:0] w_key;
    logic [CW-1:0] w_cm1;
    assign w_step = (r_hi - r_lo) >> 1;
    assign w_mid  = r_lo + w_step;
    assign w_key  = $signed(w_eta_q);
    assign w_cm1  = r_count - CW'(1);

    // memory address follows the phase
    always_comb begin
        unique case (r_state)
            S_DIV:   w_addr = r_count[AW-1:0];
            S_MID:   w_addr = r_sub == 2'd0 ? AW'(w_cm1 >> 1)
                              : (r_sub == 2'd1 ? '0 : w_cm1[AW-1:0]);
            S_SRCH:  w_addr = w_mid;
            S_BLO:   w_addr = r_lo;
            S_BHI:   w_addr = r_lo + AW'(1);
            S_CLO:   w_addr = r_lo;
            default: w_addr = '0;
        endcase
    end

    logic w_rvalid;
    assign w_rvalid = !r_radius[15] && (r_radius >= r_rlo) && (r_radius <= r_rhi)
                      && (r_rlo < r_rhi);

    logic signed [31:0] w_eta_s;
    assign w_eta_s = $signed(r_eta);

    // divider start: load row accepted, or lookup bracket with distinct keys
    logic w_dstart;
    assign w_dstart = ((r_state == S_LMUL) && w_rvalid && (r_count < CW'(TABLE_DEPTH)))
                      || ((r_state == S_CLO) && (r_sub == 2'd1) && (r_den != '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_dstart <= 1'b0;
            r_radius <= 16'hFF00;
            r_rlo    <= '0;
            r_rhi    <= '0;
            r_sub    <= '0;
        end else begin
            r_dstart <= w_dstart;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_RADIUS:      r_radius <= i_cfg_wdata;
                    REG_RADIUS_LOW:  r_rlo <= i_cfg_wdata;
                    REG_RADIUS_HIGH: r_rhi <= i_cfg_wdata;
                    default: ;
                endcase
            end
            // output word valid: set when a result loads, cleared when taken
            if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_cmd    <= s_axis_tdata[1:0];
                    r_eta    <= s_axis_tdata[33:2];
                    r_cl     <= s_axis_tdata[65:34];
                    r_ch     <= s_axis_tdata[97:66];
                    r_corr   <= '0;
                    r_status <= ST_OK;
                    r_sub    <= '0;
                    unique case (s_axis_tdata[1:0])
                        CMD_CLEAR: begin
                            r_count <= '0;
                            r_state <= S_OUT;
                        end
                        CMD_LOAD:   r_state <= S_LMUL;
                        CMD_LOOKUP: r_state <= S_MID;
                        default:    r_state <= S_OUT;
                    endcase
                end
                S_LMUL: begin
                    if (!w_rvalid) begin
                        r_status <= ST_RADIUS;
                        r_state  <= S_OUT;
                    end else if (r_count >= CW'(TABLE_DEPTH)) begin
                        r_status <= ST_FULL;
                        r_state  <= S_OUT;
                    end else begin
                        r_p0 <= 64'(r_radius - r_rlo) * 64'(r_ch);
                        r_p1 <= 64'(r_rhi - r_radius) * 64'(r_cl);
                        r_den <= 33'(r_rhi - r_rlo);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: if (w_drsp.done) begin
                    if (r_cmd == CMD_LOAD) r_count <= r_count + CW'(1);
                    else r_corr <= w_drsp.quo;
                    r_state <= S_OUT;
                end
                // checks: sign with middle key, then both ends
                S_MID: begin
                    if (r_radius[15]) begin
                        r_status <= ST_RADIUS;
                        r_state  <= S_OUT;
                    end else if (r_count == '0) begin
                        r_status <= ST_NOBRACKET;
                        r_state  <= S_OUT;
                    end else if (r_sub == 2'd0) begin
                        r_sub <= 2'd1;
                    end else if (r_sub == 2'd1) begin
                        // middle key returned
                        r_sub <= 2'd2;
                        if ((w_eta_s < 0 && w_key > 0) || (w_eta_s > 0 && w_key < 0)) begin
                            r_status <= ST_SIGN;
                            r_state  <= S_OUT;
                        end
                    end else if (r_sub == 2'd2) begin
                        // first entry returned
                        r_sub <= 2'd3;
                        if (w_eta_s > w_key && w_key > 0) begin
                            r_corr  <= w_corr_q;
                            r_state <= S_OUT;
                        end
                    end else begin
                        // last entry returned
                        r_sub <= '0;
                        if (w_eta_s < w_key && w_key < 0) begin
                            r_corr  <= w_corr_q;
                            r_state <= S_OUT;
                        end else begin
                            r_lo    <= '0;
                            r_hi    <= w_cm1[AW-1:0];
                            r_state <= S_SRCH;
                        end
                    end
                end
                // binary search: issue read, then compare
                S_SRCH: begin
                    if (w_step == '0) begin
                        r_sub   <= '0;
                        r_state <= S_BLO;
                    end else if (r_sub == 2'd0) begin
                        r_sub <= 2'd1;
                    end else begin
                        r_sub <= 2'd0;
                        if (w_key < w_eta_s) r_hi <= r_hi - w_step;
                        else r_lo <= w_mid;
                    end
                end
                S_BLO: begin
                    if (32'(r_lo) + 32'd1 >= 32'(r_count)) begin
                        r_status <= ST_NOBRACKET;
                        r_state  <= S_OUT;
                    end else if (r_sub == 2'd0) begin
                        r_sub <= 2'd1;
                    end else begin
                        r_le    <= w_eta_q;
                        r_sub   <= '0;
                        r_state <= S_BHI;
                    end
                end
                S_BHI: begin
                    if (r_sub == 2'd0) begin
                        r_sub <= 2'd1;
                    end else begin
                        r_c1  <= w_corr_q;
                        r_sub <= '0;
                        if (!($signed(r_le) >= w_eta_s && w_eta_s >= w_key)) begin
                            r_status <= ST_NOBRACKET;
                            r_state  <= S_OUT;
                        end else begin
                            r_p1  <= 64'(33'($signed(r_le)) - 33'(w_eta_s));
                            r_p0  <= 64'(33'(w_eta_s) - 33'(w_key));
                            r_den <= 33'($signed(r_le)) - 33'(w_key);
                            r_state <= S_CLO;
                        end
                    end
                end
                S_CLO: begin
                    if (r_sub == 2'd0) begin
                        r_sub <= 2'd1;
                    end else begin
                        r_sub <= '0;
                        if (r_den == '0) begin
                            r_corr  <= w_corr_q;
                            r_state <= S_OUT;
                        end else begin
                            r_p1 <= 64'(r_p1[32:0]) * 64'(r_c1);
                            r_p0 <= 64'(r_p0[32:0]) * 64'(w_corr_q);
                            r_state <= S_DIV;
                        end
                    end
                end
                // load the output word once the previous one is gone
                S_OUT: if (!r_ovalid || m_axis_tready) begin
                    r_odata <= {4'd0, 9'(r_count), r_status, r_corr};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    `ICT_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == CMD_CLEAR, r_count == '0)
    `ICT_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(TABLE_DEPTH))
    `ICT_ASSERT_IMPL(a_out_on_idle, i_clk, i_rst_n, s_axis_tready, r_state == S_IDLE)
endmodule
`default_nettype wire
